// File: rtl/core/rfpt_pkg.sv
// Shared types, constants and helpers for the fixed-point to text converter.
// Used by every module of the block but rfpt_fifo; depends on nothing.
package rfpt_pkg;

    localparam int INT_W      = 31;
    localparam int FRAC_W     = 32;
    localparam int RADIX_W    = 5;
    localparam int FRAC_CNT_W = 5;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 7;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_RADIX       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAC_DIGITS = 2'd1;

    localparam logic [RADIX_W-1:0]    RADIX_RESET       = 5'd10;
    localparam logic [RADIX_W-1:0]    RADIX_MIN         = 5'd2;
    localparam logic [RADIX_W-1:0]    RADIX_MAX         = 5'd16;
    localparam logic [FRAC_CNT_W-1:0] FRAC_DIGITS_RESET = 5'd1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE     = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_LETTER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LETTER_F = 7'h46;
    localparam logic [CHAR_W-1:0] CHAR_DOT      = 7'h2E;
    localparam logic [CHAR_W-1:0] CHAR_MINUS    = 7'h2D;

    // The integer divider works on a 32-bit dividend, eight quotient bits a cycle.
    localparam int DIV_W      = 32;
    localparam int DIV_BITS   = 8;
    localparam int DIV_CHUNKS = DIV_W / DIV_BITS;
    localparam int CHUNK_W    = $clog2(DIV_CHUNKS);

    typedef struct packed {
        logic [RADIX_W-1:0]    radix;
        logic [FRAC_CNT_W-1:0] frac_digits;
    } cfg_t;

    typedef struct packed {
        logic              emit_sign;
        logic              int_zero;
        logic              frac_nz;
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac_part;
    } item_t;

    typedef struct packed {
        logic              last;
        logic [CHAR_W-1:0] char_code;
    } out_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SIGN,
        B_ZERO,
        B_DIV,
        B_INT_LOAD,
        B_INT_EMIT,
        B_DOT,
        B_FRAC
    } back_state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
            c = CHAR_ZERO + CHAR_W'(d);
        else
            c = CHAR_LETTER_A + CHAR_W'(d - 4'd10);
        return c;
    endfunction

endpackage

// File: rtl/core/rfpt_fifo.sv
// Small first-in first-out queue of registers with a full and an empty flag.
// Generic in width and depth; uses no package.
module rfpt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_mem[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
            if (do_pop)
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// File: rtl/core/rfpt_front.sv
// Front end: holds the configuration registers, accepts numbers and classifies them.
// Depends on rfpt_pkg for the item and configuration types.
module rfpt_front #(
    parameter int MAX_FRAC_DIGITS = 28
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               negative,
    input  logic [rfpt_pkg::INT_W-1:0]         int_part,
    input  logic [rfpt_pkg::FRAC_W-1:0]        frac_part,
    input  logic                               item_full,
    output logic                               item_push,
    output rfpt_pkg::item_t                    item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rfpt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rfpt_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rfpt_pkg::cfg_t                     cfg
);

    logic [rfpt_pkg::RADIX_W-1:0]    radix_reg, radix_next;
    logic [rfpt_pkg::FRAC_CNT_W-1:0] frac_digits_reg, frac_digits_next;

    assign full      = item_full;
    assign item_push = push && !item_full;
    assign cfg_ready = 1'b1;

    // A number is signed only when it is nonzero; negative zero prints as "0".
    always_comb
    begin
        item.int_part  = int_part;
        item.frac_part = frac_part;
        item.int_zero  = (int_part == '0);
        item.frac_nz   = (frac_part != '0);
        item.emit_sign = negative && (!item.int_zero || item.frac_nz);
    end

    always_comb
    begin
        radix_next       = radix_reg;
        frac_digits_next = frac_digits_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rfpt_pkg::CFG_RADIX:
                begin
                    if (cfg_data >= rfpt_pkg::RADIX_MIN && cfg_data <= rfpt_pkg::RADIX_MAX)
                        radix_next = cfg_data;
                end
                rfpt_pkg::CFG_FRAC_DIGITS:
                begin
                    if (cfg_data > rfpt_pkg::FRAC_CNT_W'(MAX_FRAC_DIGITS))
                        frac_digits_next = rfpt_pkg::FRAC_CNT_W'(MAX_FRAC_DIGITS);
                    else
                        frac_digits_next = cfg_data;
                end
                default:
                begin
                    radix_next = radix_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= rfpt_pkg::RADIX_RESET;
            frac_digits_reg <= rfpt_pkg::FRAC_DIGITS_RESET;
        end
        else
        begin
            radix_reg       <= radix_next;
            frac_digits_reg <= frac_digits_next;
        end
    end

    assign cfg.radix       = radix_reg;
    assign cfg.frac_digits = frac_digits_reg;

endmodule

// File: rtl/core/rfpt_back.sv
// Back end: converts one queued number into characters, one character a cycle while the output queue has room.
// Depends on rfpt_pkg; holds the integer digit stack as a local memory.
module rfpt_back #(
    parameter int MAX_INT_DIGITS = 31
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rfpt_pkg::cfg_t  cfg,
    input  logic            item_empty,
    input  rfpt_pkg::item_t item,
    output logic            item_pop,
    input  logic            out_full,
    output logic            out_push,
    output rfpt_pkg::out_t  out_data
);

    localparam int AW = $clog2(MAX_INT_DIGITS);
    localparam int CW = $clog2(MAX_INT_DIGITS + 1);

    rfpt_pkg::back_state_t state_reg, state_next;

    logic [rfpt_pkg::DIV_W-1:0]      q_reg, q_next;
    logic [rfpt_pkg::RADIX_W-1:0]    rem_reg, rem_next;
    logic [rfpt_pkg::CHUNK_W-1:0]    chunk_reg, chunk_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [AW-1:0]                   k_reg, k_next;
    logic [rfpt_pkg::FRAC_W-1:0]     frac_reg, frac_next;
    logic [rfpt_pkg::FRAC_CNT_W-1:0] fcnt_reg, fcnt_next;
    logic                            frac_nz_reg, frac_nz_next;

    logic [rfpt_pkg::DIGIT_W-1:0] stack_mem [MAX_INT_DIGITS];
    logic [rfpt_pkg::DIGIT_W-1:0] rd_data_reg;
    logic                         mem_we, rd_en;
    logic [AW-1:0]                rd_addr;

    logic                                 out_ready;
    logic [rfpt_pkg::DIV_W-1:0]           q_step;
    logic [rfpt_pkg::RADIX_W-1:0]         rem_step;
    logic                                 chunk_last, div_done;
    logic [CW-1:0]                        cnt_inc;
    logic [rfpt_pkg::FRAC_W+3:0]          product;
    logic                                 frac_last;

    assign out_ready = !out_full;

    // One divider cycle: eight restoring steps on a remainder below the radix.
    always_comb
    begin
        logic [rfpt_pkg::RADIX_W:0]     trial;
        logic [rfpt_pkg::RADIX_W-1:0]   rem_work;
        logic [rfpt_pkg::DIV_BITS-1:0]  qbits;
        rem_work = rem_reg;
        qbits    = '0;
        for (int i = 0; i < rfpt_pkg::DIV_BITS; i++)
        begin
            trial = {rem_work, q_reg[rfpt_pkg::DIV_W-1-i]};
            if (trial >= {1'b0, cfg.radix})
            begin
                trial = trial - {1'b0, cfg.radix};
                qbits[rfpt_pkg::DIV_BITS-1-i] = 1'b1;
            end
            rem_work = trial[rfpt_pkg::RADIX_W-1:0];
        end
        rem_step = rem_work;
        q_step   = {q_reg[rfpt_pkg::DIV_W-rfpt_pkg::DIV_BITS-1:0], qbits};
    end

    assign chunk_last = (chunk_reg == rfpt_pkg::CHUNK_W'(rfpt_pkg::DIV_CHUNKS - 1));
    assign cnt_inc    = cnt_reg + CW'(1);
    assign div_done   = chunk_last && ((q_step == '0) || (cnt_inc == CW'(MAX_INT_DIGITS)));

    // Fraction digit: the top bits of remainder times radix, the rest carries on.
    assign product   = frac_reg * (rfpt_pkg::FRAC_W + 4)'(cfg.radix);
    assign frac_last = (product[rfpt_pkg::FRAC_W-1:0] == '0)
                       || (fcnt_reg == cfg.frac_digits - rfpt_pkg::FRAC_CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rfpt_pkg::B_IDLE:
            begin
                if (!item_empty)
                begin
                    if (item.emit_sign)
                        state_next = rfpt_pkg::B_SIGN;
                    else if (item.int_zero)
                        state_next = rfpt_pkg::B_ZERO;
                    else
                        state_next = rfpt_pkg::B_DIV;
                end
            end
            rfpt_pkg::B_SIGN:
            begin
                if (out_ready)
                    state_next = (q_reg == '0) ? rfpt_pkg::B_ZERO : rfpt_pkg::B_DIV;
            end
            rfpt_pkg::B_ZERO:
            begin
                if (out_ready)
                    state_next = frac_nz_reg ? rfpt_pkg::B_DOT : rfpt_pkg::B_IDLE;
            end
            rfpt_pkg::B_DIV:
            begin
                if (div_done)
                    state_next = rfpt_pkg::B_INT_LOAD;
            end
            rfpt_pkg::B_INT_LOAD:
            begin
                state_next = rfpt_pkg::B_INT_EMIT;
            end
            rfpt_pkg::B_INT_EMIT:
            begin
                if (out_ready && k_reg == '0)
                    state_next = frac_nz_reg ? rfpt_pkg::B_DOT : rfpt_pkg::B_IDLE;
            end
            rfpt_pkg::B_DOT:
            begin
                if (out_ready)
                    state_next = (cfg.frac_digits == '0) ? rfpt_pkg::B_IDLE : rfpt_pkg::B_FRAC;
            end
            rfpt_pkg::B_FRAC:
            begin
                if (out_ready && frac_last)
                    state_next = rfpt_pkg::B_IDLE;
            end
            default:
            begin
                state_next = rfpt_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_pop           = 1'b0;
        out_push           = 1'b0;
        out_data.last      = 1'b0;
        out_data.char_code = rfpt_pkg::CHAR_ZERO;
        mem_we             = 1'b0;
        rd_en              = 1'b0;
        rd_addr            = k_reg;
        q_next             = q_reg;
        rem_next           = rem_reg;
        chunk_next         = chunk_reg;
        cnt_next           = cnt_reg;
        k_next             = k_reg;
        frac_next          = frac_reg;
        fcnt_next          = fcnt_reg;
        frac_nz_next       = frac_nz_reg;
        unique case (state_reg)
            rfpt_pkg::B_IDLE:
            begin
                item_pop     = !item_empty;
                q_next       = {1'b0, item.int_part};
                rem_next     = '0;
                chunk_next   = '0;
                cnt_next     = '0;
                frac_next    = item.frac_part;
                fcnt_next    = '0;
                frac_nz_next = item.frac_nz;
            end
            rfpt_pkg::B_SIGN:
            begin
                out_push           = out_ready;
                out_data.char_code = rfpt_pkg::CHAR_MINUS;
            end
            rfpt_pkg::B_ZERO:
            begin
                out_push      = out_ready;
                out_data.last = !frac_nz_reg;
            end
            rfpt_pkg::B_DIV:
            begin
                q_next     = q_step;
                chunk_next = chunk_reg + rfpt_pkg::CHUNK_W'(1);
                rem_next   = rem_step;
                if (chunk_last)
                begin
                    mem_we     = 1'b1;
                    cnt_next   = cnt_inc;
                    rem_next   = '0;
                    chunk_next = '0;
                end
            end
            rfpt_pkg::B_INT_LOAD:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(cnt_reg - CW'(1));
                k_next  = AW'(cnt_reg - CW'(1));
            end
            rfpt_pkg::B_INT_EMIT:
            begin
                out_push           = out_ready;
                out_data.char_code = rfpt_pkg::digit_char(rd_data_reg);
                out_data.last      = (k_reg == '0) && !frac_nz_reg;
                if (out_ready && k_reg != '0)
                begin
                    rd_en   = 1'b1;
                    rd_addr = k_reg - AW'(1);
                    k_next  = k_reg - AW'(1);
                end
            end
            rfpt_pkg::B_DOT:
            begin
                out_push           = out_ready;
                out_data.char_code = rfpt_pkg::CHAR_DOT;
                out_data.last      = (cfg.frac_digits == '0);
            end
            rfpt_pkg::B_FRAC:
            begin
                out_push           = out_ready;
                out_data.char_code = rfpt_pkg::digit_char(
                    product[rfpt_pkg::FRAC_W+3:rfpt_pkg::FRAC_W]);
                out_data.last      = frac_last;
                if (out_ready)
                begin
                    frac_next = product[rfpt_pkg::FRAC_W-1:0];
                    fcnt_next = fcnt_reg + rfpt_pkg::FRAC_CNT_W'(1);
                end
            end
            default:
            begin
                item_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[cnt_reg[AW-1:0]] <= rem_step[rfpt_pkg::DIGIT_W-1:0];
        if (rd_en)
            rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rfpt_pkg::B_IDLE;
            chunk_reg   <= '0;
            cnt_reg     <= '0;
            k_reg       <= '0;
            fcnt_reg    <= '0;
            frac_nz_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chunk_reg   <= chunk_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            fcnt_reg    <= fcnt_next;
            frac_nz_reg <= frac_nz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        frac_reg <= frac_next;
    end

endmodule

// File: rtl/core/radix_fixed_point_to_text.sv
// Top level of the fixed-point to text converter.
// Instantiates rfpt_front, two rfpt_fifo queues and rfpt_back; uses rfpt_pkg.
//
// Each accepted item is a signed fixed-point number (sign, 31-bit integer
// magnitude, Q0.32 fraction) and comes out as ASCII text in the configured
// radix, one character per result item, with last set on the final one: an
// optional '-', the integer digits most significant first ('0' for a zero
// integer part), then '.' and up to frac_digits fraction digits when the
// fraction is nonzero. An item is taken in the idle state, the iterative
// divider then produces each integer digit (eight quotient bits a cycle over
// a 32-bit dividend), a load state starts reading the digit stack, and the
// characters are then emitted one a cycle while the output queue has room.
// Fraction digits come from a single 32 by 5 bit multiply at one per cycle
// while the output queue has room. The input queue takes further items while
// one is converted, and the output queue holds finished characters until popped.
// Configuration is written through its own channel, which is always ready;
// the back end reads the registers live, so write them only while no number
// is in flight.
module radix_fixed_point_to_text #(
    parameter int MAX_INT_DIGITS   = 31,
    parameter int MAX_FRAC_DIGITS  = 28,
    parameter int ITEM_QUEUE_DEPTH = 2,
    parameter int OUT_QUEUE_DEPTH  = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             negative,
    input  logic [rfpt_pkg::INT_W-1:0]       int_part,
    input  logic [rfpt_pkg::FRAC_W-1:0]      frac_part,
    output logic                             empty,
    input  logic                             pop,
    output logic [rfpt_pkg::CHAR_W-1:0]      char_code,
    output logic                             last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rfpt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rfpt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ITEM_W = $bits(rfpt_pkg::item_t);
    localparam int OUT_W  = $bits(rfpt_pkg::out_t);

    rfpt_pkg::cfg_t  cfg;
    rfpt_pkg::item_t front_item, queued_item;
    rfpt_pkg::out_t  back_out, queued_out;
    logic            item_push, item_full, item_pop, item_empty;
    logic            out_push, out_full;

    // The front classifies each number as it enters: sign wanted, zero
    // integer part, nonzero fraction.
    rfpt_front #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .negative  (negative),
        .int_part  (int_part),
        .frac_part (frac_part),
        .item_full (item_full),
        .item_push (item_push),
        .item      (front_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The item queue lets the front take new numbers while the back works.
    rfpt_fifo #(
        .WIDTH(ITEM_W),
        .DEPTH(ITEM_QUEUE_DEPTH)
    ) u_item_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (item_push),
        .wr_data (front_item),
        .full    (item_full),
        .pop     (item_pop),
        .rd_data (queued_item),
        .empty   (item_empty)
    );

    // The back runs the divider, the digit stack and the fraction multiply.
    rfpt_back #(
        .MAX_INT_DIGITS(MAX_INT_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_empty (item_empty),
        .item       (queued_item),
        .item_pop   (item_pop),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_data   (back_out)
    );

    // Characters wait here until the consumer pops them.
    rfpt_fifo #(
        .WIDTH(OUT_W),
        .DEPTH(OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (back_out),
        .full    (out_full),
        .pop     (pop),
        .rd_data (queued_out),
        .empty   (empty)
    );

    assign char_code = queued_out.char_code;
    assign last      = queued_out.last;

endmodule

// File: rtl/core/rfpt_checker.sv
// Port-level checks on the converter's output stream, bound to the top level.
// Depends on rfpt_pkg for character codes and on radix_fixed_point_to_text for the bind.
module rfpt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [rfpt_pkg::CHAR_W-1:0] char_code,
    input logic                        last
);

    logic [7:0] pending_reg, pending_next;
    logic       in_acc, num_done;

    assign in_acc   = push && !full;
    assign num_done = pop && !empty && last;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !num_done)
            pending_next = pending_reg + 8'd1;
        else if (num_done && !in_acc)
            pending_next = pending_reg - 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // Every shown character is a digit, a point or a minus sign.
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((char_code >= rfpt_pkg::CHAR_ZERO && char_code <= rfpt_pkg::CHAR_NINE)
                 || (char_code >= rfpt_pkg::CHAR_LETTER_A
                     && char_code <= rfpt_pkg::CHAR_LETTER_F)
                 || char_code == rfpt_pkg::CHAR_DOT
                 || char_code == rfpt_pkg::CHAR_MINUS))
        else $error("illegal character on the result port");

    // A minus sign always has digits after it.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && char_code == rfpt_pkg::CHAR_MINUS) |-> !last)
        else $error("minus sign flagged as last character");

    // Characters only appear for numbers that were accepted and not yet finished.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pending_reg != 8'd0))
        else $error("result shown with no number outstanding");

    // A waiting character stays put until it is popped.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(char_code) && $stable(last)))
        else $error("waiting result changed before pop");

endmodule

bind radix_fixed_point_to_text rfpt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .char_code (char_code),
    .last      (last)
);
